FILE: rtl/dvrt_pkg.sv
// ----------------------------------------------------------------------------
// dvrt_pkg
// Shared types and constants of the distance-vector route table unit.
// ----------------------------------------------------------------------------
package dvrt_pkg;

  localparam int NODE_COUNT = 256;
  localparam int PORT_COUNT = 16;
  localparam int COST_BITS  = 16;
  localparam int NODE_BITS  = 8;
  localparam int PORT_BITS  = 4;

  localparam logic [COST_BITS-1:0] COST_INF = {COST_BITS{1'b1}};

  localparam logic [1:0] OP_LINK   = 2'd0;
  localparam logic [1:0] OP_VECTOR = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  typedef logic [COST_BITS-1:0] cost_t;
  typedef logic [NODE_BITS-1:0] node_t;
  typedef logic [PORT_BITS-1:0] port_t;

  // one queued operation between front and back
  typedef struct packed {
    logic [1:0] opcode;
    port_t      in_port;
    node_t      node_id;
    cost_t      cost;
    logic       last_entry;
  } cmd_t;

  typedef struct packed {
    logic  changed;
    logic  found;
    port_t fwd_port;
    logic  deliver_local;
  } rsp_t;

  function automatic cost_t sat_add(input cost_t a, input cost_t b);
    logic [COST_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = (s >= {1'b0, COST_INF}) ? COST_INF : s[COST_BITS-1:0];
  endfunction

endpackage

FILE: rtl/dvrt_front.sv
// ----------------------------------------------------------------------------
// dvrt_front
// Input stage: registers accepted beats into a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module dvrt_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  dvrt_pkg::cmd_t in_cmd,
  output logic          q_valid,
  input  logic          q_ready,
  output dvrt_pkg::cmd_t q_cmd
);
  import dvrt_pkg::*;

  cmd_t       slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      slot[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (in_valid && in_ready) wr_ptr <= ~wr_ptr;
      if (q_valid && q_ready) rd_ptr <= ~rd_ptr;
      count <= count + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
    end
  end

endmodule

FILE: rtl/dvrt_back.sv
// ----------------------------------------------------------------------------
// dvrt_back
// Engine: owns port and route tables, answers lookups, runs link-update and vector sweeps
// over the route memory one destination at a time, with fallback port walks.
// ----------------------------------------------------------------------------
module dvrt_back (
  input  logic           clk,
  input  logic           rst,
  input  dvrt_pkg::node_t own_id,
  input  logic           q_valid,
  output logic           q_ready,
  input  dvrt_pkg::cmd_t q_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output dvrt_pkg::rsp_t out_rsp
);
  import dvrt_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LRD    = 4'd1;
  localparam logic [3:0] S_LWAIT  = 4'd2;
  localparam logic [3:0] S_LCALC  = 4'd3;
  localparam logic [3:0] S_FB     = 4'd4;
  localparam logic [3:0] S_DIRRD  = 4'd5;
  localparam logic [3:0] S_DIRWT  = 4'd6;
  localparam logic [3:0] S_DIRUP  = 4'd7;
  localparam logic [3:0] S_SRD    = 4'd8;
  localparam logic [3:0] S_SWAIT  = 4'd9;
  localparam logic [3:0] S_SCALC  = 4'd10;
  localparam logic [3:0] S_LKWAIT = 4'd11;
  localparam logic [3:0] S_LKUP   = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;
  localparam logic [3:0] S_CLR    = 4'd14;

  // port table in flops
  node_t port_neighbour [PORT_COUNT];
  logic  port_has_neighbour [PORT_COUNT];
  cost_t port_cost [PORT_COUNT];

  // route and vector memories
  cost_t route_cost_mem [NODE_COUNT];
  port_t route_port_mem [NODE_COUNT];
  cost_t vector_cost_mem [NODE_COUNT];
  logic [NODE_COUNT-1:0] route_valid;
  logic [NODE_COUNT-1:0] vector_seen;

  logic [3:0] state;
  cmd_t       cmd;
  node_t      idx;
  logic       idx_last;
  logic       chg;
  cost_t      prev_c;
  cost_t      link_c;
  cost_t      cur_cost;
  port_t      cur_port;
  port_t      fb_q;
  logic       fb_from_sweep;
  logic       sweep_p2;

  node_t rd_addr;
  cost_t rd_rc;
  port_t rd_rp;
  cost_t rd_vc;

  logic  wr_en;
  node_t wr_addr;
  cost_t wr_cost;
  port_t wr_port;

  always_ff @(posedge clk) begin
    rd_rc <= route_cost_mem[rd_addr];
    rd_rp <= route_port_mem[rd_addr];
    rd_vc <= vector_cost_mem[rd_addr];
    if (wr_en) begin
      route_cost_mem[wr_addr] <= wr_cost;
      route_port_mem[wr_addr] <= wr_port;
    end
    if (q_valid && q_ready && q_cmd.opcode == OP_VECTOR &&
        port_cost[q_cmd.in_port] != COST_INF && q_cmd.node_id != own_id &&
        !vector_seen[q_cmd.node_id]) begin
      vector_cost_mem[q_cmd.node_id] <= q_cmd.cost;
    end
  end

  assign q_ready   = (state == S_IDLE) && !out_valid;
  assign rd_addr   = (state == S_IDLE) ? q_cmd.node_id : idx;

  // combinational per-destination decisions
  cost_t           lk_new;
  logic [COST_BITS:0] up;
  cost_t           sum;
  cost_t           sw_new;
  logic            fb_hit;
  logic            nb_skip;

  always_comb begin
    up = {1'b0, cur_cost} + {1'b0, link_c};
    if (link_c == COST_INF) lk_new = COST_INF;
    else if (up < {1'b0, prev_c}) lk_new = '0;
    else if (up - {1'b0, prev_c} >= {1'b0, COST_INF}) lk_new = COST_INF;
    else lk_new = COST_BITS'(up - {1'b0, prev_c});
    sum     = sat_add(link_c, rd_vc);
    sw_new  = (rd_vc == COST_INF) ? COST_INF : sum;
    fb_hit  = port_has_neighbour[fb_q] && port_neighbour[fb_q] == idx &&
              port_cost[fb_q] < cur_cost;
    nb_skip = port_has_neighbour[cmd.in_port] &&
              port_neighbour[cmd.in_port] == idx;
  end

  always_ff @(posedge clk) begin
    wr_en <= 1'b0;
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      route_valid <= '0;
      vector_seen <= '0;
      chg         <= 1'b0;
      for (int i = 0; i < PORT_COUNT; i++) begin
        port_neighbour[i]     <= '0;
        port_has_neighbour[i] <= 1'b0;
        port_cost[i]          <= COST_INF;
      end
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            cmd     <= q_cmd;
            out_rsp <= '0;
            chg     <= 1'b0;
            // a lookup keeps reading its destination while it waits
            idx     <= (q_cmd.opcode == OP_LOOKUP) ? q_cmd.node_id : '0;
            unique case (q_cmd.opcode)
              OP_LINK: begin
                prev_c <= port_cost[q_cmd.in_port];
                link_c <= q_cmd.cost;
                port_neighbour[q_cmd.in_port]     <= q_cmd.node_id;
                port_has_neighbour[q_cmd.in_port] <= 1'b1;
                port_cost[q_cmd.in_port]          <= q_cmd.cost;
                if (port_cost[q_cmd.in_port] != COST_INF &&
                    port_cost[q_cmd.in_port] != q_cmd.cost) state <= S_LRD;
                else state <= S_DIRRD;
              end
              OP_VECTOR: begin
                link_c <= port_cost[q_cmd.in_port];
                if (port_cost[q_cmd.in_port] == COST_INF) begin
                  if (q_cmd.last_entry) vector_seen <= '0;
                  state <= S_DONE;
                end else begin
                  if (q_cmd.node_id != own_id) vector_seen[q_cmd.node_id] <= 1'b1;
                  if (q_cmd.last_entry) begin
                    sweep_p2 <= 1'b0;
                    state    <= S_SRD;
                  end else state <= S_DONE;
                end
              end
              OP_LOOKUP: state <= S_LKWAIT;
              default:   state <= S_DONE;
            endcase
          end
        end
        // link sweep: read, wait, compute
        S_LRD:   state <= S_LWAIT;
        S_LWAIT: begin
          cur_cost <= rd_rc;
          cur_port <= rd_rp;
          state    <= S_LCALC;
        end
        S_LCALC: begin
          idx_last <= (idx == node_t'(NODE_COUNT - 1));
          if (route_valid[idx] && cur_port == cmd.in_port && cur_cost != COST_INF) begin
            chg     <= 1'b1;
            wr_en   <= 1'b1;
            wr_addr <= idx;
            wr_cost <= lk_new;
            wr_port <= cur_port;
            if (lk_new > cur_cost) begin
              cur_cost      <= lk_new;
              fb_q          <= '0;
              fb_from_sweep <= 1'b0;
              state         <= S_FB;
            end else if (idx == node_t'(NODE_COUNT - 1)) state <= S_DIRRD;
            else begin
              idx   <= idx + 1'b1;
              state <= S_LRD;
            end
          end else if (idx == node_t'(NODE_COUNT - 1)) state <= S_DIRRD;
          else begin
            idx   <= idx + 1'b1;
            state <= S_LRD;
          end
        end
        // walk ports for a cheaper direct link to idx
        S_FB: begin
          if (fb_hit) begin
            wr_en   <= 1'b1;
            wr_addr <= idx;
            wr_cost <= port_cost[fb_q];
            wr_port <= fb_q;
          end
          if (fb_hit || fb_q == port_t'(PORT_COUNT - 1)) begin
            if (idx_last) state <= fb_from_sweep ? S_SRD : S_DIRRD;
            else state <= fb_from_sweep ? S_SRD : S_LRD;
            if (fb_from_sweep && idx_last) sweep_p2 <= 1'b1;
            idx <= idx + 1'b1;
          end else fb_q <= fb_q + 1'b1;
        end
        S_DIRRD: begin
          idx   <= cmd.node_id;
          state <= S_DIRWT;
        end
        S_DIRWT: state <= S_DIRUP;
        S_DIRUP: begin
          if (link_c != COST_INF) begin
            if (!route_valid[idx] || link_c < rd_rc) begin
              route_valid[idx] <= 1'b1;
              wr_en   <= 1'b1;
              wr_addr <= idx;
              wr_cost <= link_c;
              wr_port <= cmd.in_port;
              chg     <= 1'b1;
              out_rsp.changed <= 1'b1;
            end else out_rsp.changed <= chg;
          end else out_rsp.changed <= chg;
          state <= S_DONE;
        end
        // vector sweep, pass 1 update, pass 2 install
        S_SRD:   state <= S_SWAIT;
        S_SWAIT: begin
          cur_cost <= rd_rc;
          cur_port <= rd_rp;
          state    <= S_SCALC;
        end
        S_SCALC: begin
          idx_last <= (idx == node_t'(NODE_COUNT - 1));
          if (idx == node_t'(NODE_COUNT - 1)) sweep_p2 <= 1'b1;
          idx   <= idx + 1'b1;
          state <= (idx == node_t'(NODE_COUNT - 1) && sweep_p2) ? S_CLR : S_SRD;
          if (sweep_p2) begin
            if (vector_seen[idx] && !route_valid[idx]) begin
              route_valid[idx] <= 1'b1;
              wr_en   <= 1'b1;
              wr_addr <= idx;
              wr_cost <= sum;
              wr_port <= cmd.in_port;
              chg     <= 1'b1;
            end
          end else if (route_valid[idx] && !nb_skip) begin
            if (vector_seen[idx]) begin
              if (cur_port == cmd.in_port) begin
                wr_en   <= 1'b1;
                wr_addr <= idx;
                wr_cost <= sw_new;
                wr_port <= cur_port;
                if (sw_new != cur_cost) chg <= 1'b1;
                if (sw_new > cur_cost) begin
                  cur_cost      <= sw_new;
                  fb_q          <= '0;
                  fb_from_sweep <= 1'b1;
                  idx           <= idx;
                  state         <= S_FB;
                end
              end else if (sum < cur_cost) begin
                wr_en   <= 1'b1;
                wr_addr <= idx;
                wr_cost <= sum;
                wr_port <= cmd.in_port;
                chg     <= 1'b1;
              end
            end else if (cur_port == cmd.in_port && cur_cost != COST_INF) begin
              wr_en   <= 1'b1;
              wr_addr <= idx;
              wr_cost <= COST_INF;
              wr_port <= cur_port;
              chg     <= 1'b1;
              cur_cost      <= COST_INF;
              fb_q          <= '0;
              fb_from_sweep <= 1'b1;
              idx           <= idx;
              state         <= S_FB;
            end
          end
        end
        S_CLR: begin
          vector_seen     <= '0;
          out_rsp.changed <= chg;
          state           <= S_DONE;
        end
        S_LKWAIT: state <= S_LKUP;
        S_LKUP: begin
          if (cmd.node_id == own_id) out_rsp.deliver_local <= 1'b1;
          else if (route_valid[cmd.node_id] && rd_rc != COST_INF) begin
            out_rsp.found    <= 1'b1;
            out_rsp.fwd_port <= rd_rp;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/distance_vector_route_table_unit.sv
// ----------------------------------------------------------------------------
// distance_vector_route_table_unit
// Distance-vector route table: link updates, vector entries, lookups.
// ----------------------------------------------------------------------------
// The engine takes a new beat only when idle with no result pending. A link
// update that changes a finite cost walks the 256 routes; a last vector entry
// on a port of finite cost walks them twice. Each route that gets worse adds
// a walk over up to 16 ports.
// Synchronous active-high reset clears own id, port table, valid and seen bits.
module distance_vector_route_table_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [3:0]  in_port,
  input  logic [7:0]  node_id,
  input  logic [15:0] cost,
  input  logic        last_entry,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        changed,
  output logic        found,
  output logic [3:0]  fwd_port,
  output logic        deliver_local
);
  import dvrt_pkg::*;

  node_t own_id;
  cmd_t  in_cmd;
  cmd_t  q_cmd;
  logic  q_valid;
  logic  q_ready;
  rsp_t  rsp;

  always_ff @(posedge clk) begin
    if (rst) own_id <= '0;
    else if (cfg_we) own_id <= cfg_wdata;
  end

  assign in_cmd = '{opcode: opcode, in_port: in_port, node_id: node_id,
                    cost: cost, last_entry: last_entry};

  dvrt_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  dvrt_back u_back (
    .clk(clk), .rst(rst), .own_id(own_id), .q_valid(q_valid),
    .q_ready(q_ready), .q_cmd(q_cmd), .out_valid(out_valid),
    .out_ready(out_ready), .out_rsp(rsp)
  );

  assign changed       = rsp.changed;
  assign found         = rsp.found;
  assign fwd_port      = rsp.fwd_port;
  assign deliver_local = rsp.deliver_local;

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(found && deliver_local))
    else $error("found and local delivery both set");

  assert property (@(posedge clk) disable iff (rst)
    q_valid && q_ready |-> !out_valid)
    else $error("engine took a beat with a result pending");

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives link updates, vector entries and lookups into the route table unit
// with random idling on both sides. An in-bench route table model predicts
// each response, and a checker compares every response field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dvrt_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  opcode;
  logic [3:0]  in_port;
  logic [7:0]  node_id;
  logic [15:0] cost;
  logic        last_entry;
  logic        out_valid;
  logic        out_ready;
  logic        changed;
  logic        found;
  logic [3:0]  fwd_port;
  logic        deliver_local;

  distance_vector_route_table_unit u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
    .in_port(in_port), .node_id(node_id), .cost(cost),
    .last_entry(last_entry), .out_valid(out_valid), .out_ready(out_ready),
    .changed(changed), .found(found), .fwd_port(fwd_port),
    .deliver_local(deliver_local)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // route table shadow
  node_t  m_own;
  node_t  m_nbr [PORT_COUNT];
  logic   m_has [PORT_COUNT];
  cost_t  m_pcost [PORT_COUNT];
  logic   m_rvalid [NODE_COUNT];
  cost_t  m_rcost [NODE_COUNT];
  port_t  m_rport [NODE_COUNT];
  logic   m_seen [NODE_COUNT];
  cost_t  m_vcost [NODE_COUNT];

  rsp_t   expected_rsp [$];
  int     fail_count;
  int     rsp_count;
  int     changed_count;
  int     found_count;
  bit     hold_off;

  function automatic cost_t add_sat(cost_t a, cost_t b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= 17'h0ffff) ? COST_INF : s[15:0];
  endfunction

  function automatic void try_direct(int d);
    for (int q = 0; q < PORT_COUNT; q++) begin
      if (m_has[q] && m_nbr[q] == d && m_pcost[q] < m_rcost[d]) begin
        m_rcost[d] = m_pcost[q];
        m_rport[d] = port_t'(q);
        return;
      end
    end
  endfunction

  function automatic logic apply_link(port_t p, node_t nb, cost_t nc);
    cost_t prev;
    cost_t was;
    logic  chg;
    logic [16:0] up;
    prev = m_pcost[p];
    chg = 1'b0;
    m_nbr[p] = nb;
    m_has[p] = 1'b1;
    m_pcost[p] = nc;
    if (prev != COST_INF && prev != nc) begin
      for (int d = 0; d < NODE_COUNT; d++) begin
        if (!m_rvalid[d] || m_rport[d] != p || m_rcost[d] == COST_INF) continue;
        was = m_rcost[d];
        if (nc == COST_INF) begin
          m_rcost[d] = COST_INF;
        end else begin
          up = {1'b0, was} + {1'b0, nc};
          if (up < {1'b0, prev}) m_rcost[d] = '0;
          else if (up - prev >= 17'h0ffff) m_rcost[d] = COST_INF;
          else m_rcost[d] = 16'(up - prev);
        end
        chg = 1'b1;
        if (m_rcost[d] > was) try_direct(d);
      end
    end
    if (nc != COST_INF) begin
      if (m_rvalid[nb]) begin
        if (nc < m_rcost[nb]) begin
          m_rcost[nb] = nc;
          m_rport[nb] = p;
          chg = 1'b1;
        end
      end else begin
        m_rvalid[nb] = 1'b1;
        m_rcost[nb] = nc;
        m_rport[nb] = p;
        chg = 1'b1;
      end
    end
    return chg;
  endfunction

  function automatic logic apply_vector(port_t p);
    cost_t c;
    cost_t s;
    cost_t sum;
    cost_t prev;
    logic  chg;
    c = m_pcost[p];
    chg = 1'b0;
    for (int d = 0; d < NODE_COUNT; d++) begin
      if (!m_rvalid[d]) continue;
      if (m_has[p] && d == m_nbr[p]) continue;
      if (m_seen[d]) begin
        s = m_vcost[d];
        sum = add_sat(c, s);
        if (m_rport[d] == p) begin
          prev = m_rcost[d];
          m_rcost[d] = (s == COST_INF) ? COST_INF : sum;
          if (m_rcost[d] != prev) begin
            chg = 1'b1;
            if (m_rcost[d] > prev) try_direct(d);
          end
        end else if (sum < m_rcost[d]) begin
          m_rcost[d] = sum;
          m_rport[d] = p;
          chg = 1'b1;
        end
      end else if (m_rport[d] == p && m_rcost[d] != COST_INF) begin
        m_rcost[d] = COST_INF;
        chg = 1'b1;
        try_direct(d);
      end
    end
    for (int d = 0; d < NODE_COUNT; d++) begin
      if (m_seen[d] && !m_rvalid[d]) begin
        m_rvalid[d] = 1'b1;
        m_rcost[d] = add_sat(c, m_vcost[d]);
        m_rport[d] = p;
        chg = 1'b1;
      end
    end
    return chg;
  endfunction

  function automatic rsp_t predict_route(logic [1:0] op, port_t p, node_t n, cost_t c,
                                         logic last);
    rsp_t r;
    r = '0;
    case (op)
      OP_LINK: begin
        r.changed = apply_link(p, n, c);
      end
      OP_VECTOR: begin
        if (m_pcost[p] != COST_INF) begin
          if (n != m_own && !m_seen[n]) begin
            m_seen[n] = 1'b1;
            m_vcost[n] = c;
          end
          if (last) r.changed = apply_vector(p);
        end
        if (last) foreach (m_seen[i]) m_seen[i] = 1'b0;
      end
      OP_LOOKUP: begin
        if (n == m_own) begin
          r.deliver_local = 1'b1;
        end else if (m_rvalid[n] && m_rcost[n] != COST_INF) begin
          r.found = 1'b1;
          r.fwd_port = m_rport[n];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // valid stays high across back-to-back beats; drop it only to idle
  task automatic send_op(logic [1:0] op, port_t p, node_t n, cost_t c, logic last);
    int   gap;
    rsp_t r;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    in_port    <= p;
    node_id    <= n;
    cost       <= c;
    last_entry <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = predict_route(op, p, n, c, last);
    expected_rsp.insert(expected_rsp.size(), r);
    @(negedge clk);
  endtask

  // wait for all responses plus walk time before touching own_id
  task automatic set_own_id(node_t v);
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_rsp.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (20) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    m_own = v;
  endtask

  function automatic cost_t rand_cost();
    case ($urandom_range(0, 5))
      0: return COST_INF;
      1: return 16'hfffe;
      2: return '0;
      3: return cost_t'($urandom_range(16'h8000, 16'hfffe));
      default: return cost_t'($urandom_range(1, 40));
    endcase
  endfunction

  task automatic test_directed();
    send_op(OP_LOOKUP, 4'd0, 8'd0, '0, 1'b0);
    send_op(OP_LOOKUP, 4'd15, 8'd255, 16'hffff, 1'b1);
    send_op(OP_VECTOR, 4'd3, 8'd9, 16'd4, 1'b1);      // dead port, dropped
    send_op(OP_LINK, 4'd0, 8'd10, 16'd5, 1'b0);
    send_op(OP_LINK, 4'd15, 8'd255, 16'hfffe, 1'b1);
    send_op(OP_LINK, 4'd1, 8'd10, 16'd2, 1'b0);
    send_op(OP_VECTOR, 4'd0, 8'd20, 16'd3, 1'b0);
    send_op(OP_VECTOR, 4'd0, 8'd20, 16'd9, 1'b0);     // duplicate, first wins
    send_op(OP_VECTOR, 4'd0, 8'd0, 16'd1, 1'b0);      // own id, skipped
    send_op(OP_VECTOR, 4'd0, 8'd30, 16'hffff, 1'b0);
    send_op(OP_VECTOR, 4'd0, 8'd40, 16'hfff0, 1'b1);  // large cost, sum stays finite
    send_op(OP_LOOKUP, 4'd0, 8'd20, '0, 1'b0);
    send_op(OP_LINK, 4'd0, 8'd10, 16'd1, 1'b0);       // cheaper link, routes shift down
    send_op(OP_LINK, 4'd0, 8'd10, 16'd50, 1'b0);      // worse, walks ports for a fallback
    send_op(OP_LOOKUP, 4'd0, 8'd10, '0, 1'b0);
    send_op(OP_VECTOR, 4'd0, 8'd50, 16'd1, 1'b1);     // missing entries go infinite
    send_op(OP_LINK, 4'd1, 8'd10, 16'hffff, 1'b0);    // link down
    send_op(OP_LOOKUP, 4'd0, 8'd20, '0, 1'b0);
    send_op(OP_SPARE, 4'd7, 8'd77, 16'd7, 1'b1);      // unused opcode
    send_op(OP_LOOKUP, 4'd0, 8'd0, '0, 1'b0);
  endtask

  task automatic test_random(int count, int ports);
    int sent;
    int len;
    port_t p;
    sent = 0;
    while (sent < count) begin
      p = port_t'($urandom_range(0, ports - 1));
      case ($urandom_range(0, 9)) inside
        [0:2]: begin
          send_op(OP_LINK, p, node_t'($urandom_range(0, 15)), rand_cost(),
                  1'($urandom_range(0, 1)));
          sent++;
        end
        [3:6]: begin
          len = $urandom_range(1, 8);
          for (int k = 0; k < len; k++) begin
            send_op(OP_VECTOR, p, ($urandom_range(0, 7) == 0)
                    ? node_t'($urandom_range(0, 255)) : node_t'($urandom_range(0, 23)),
                    rand_cost(), k == len - 1);
            sent++;
          end
        end
        7: begin
          send_op(2'($urandom_range(0, 3)), port_t'($urandom_range(0, 15)),
                  node_t'($urandom_range(0, 255)), cost_t'($urandom_range(0, 65535)),
                  1'($urandom_range(0, 1)));
          sent++;
        end
        default: begin
          send_op(OP_LOOKUP, port_t'($urandom_range(0, 15)), ($urandom_range(0, 3) == 0)
                  ? node_t'($urandom_range(0, 255)) : node_t'($urandom_range(0, 23)),
                  cost_t'($urandom), 1'b0);
          sent++;
        end
      endcase
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int k = 0; k < 12; k++) send_op(OP_LOOKUP, 4'd0, node_t'(k), '0, 1'b0);
    hold_off = 1'b0;
  endtask

  // receiver: random stalls, or a long hold while hold_off is set
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) stall = 300;
      else if ($urandom_range(0, 2) == 0) stall = $urandom_range(0, 7);
      else stall = 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    rsp_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected response changed=%b found=%b port=%0d local=%b",
                 $time, changed, found, fwd_port, deliver_local);
        fail_count++;
      end else begin
        exp_r = expected_rsp.pop_front();
        rsp_count++;
        changed_count += changed;
        found_count += found;
        if (changed !== exp_r.changed) begin
          $display("%0t: changed expected %b actual %b", $time, exp_r.changed, changed);
          fail_count++;
        end
        if (found !== exp_r.found) begin
          $display("%0t: found expected %b actual %b", $time, exp_r.found, found);
          fail_count++;
        end
        if (fwd_port !== exp_r.fwd_port) begin
          $display("%0t: fwd_port expected %0d actual %0d", $time, exp_r.fwd_port,
                   fwd_port);
          fail_count++;
        end
        if (deliver_local !== exp_r.deliver_local) begin
          $display("%0t: deliver_local expected %b actual %b", $time,
                   exp_r.deliver_local, deliver_local);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #200ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst = 1'b1; cfg_we = 1'b0; cfg_wdata = '0; in_valid = 1'b0; opcode = '0;
    in_port = '0; node_id = '0; cost = '0; last_entry = 1'b0;
    fail_count = 0; rsp_count = 0; changed_count = 0; found_count = 0;
    hold_off = 1'b0;
    m_own = '0;
    foreach (m_nbr[i]) begin
      m_nbr[i] = '0; m_has[i] = 1'b0; m_pcost[i] = COST_INF;
    end
    foreach (m_rvalid[i]) begin
      m_rvalid[i] = 1'b0; m_rcost[i] = '0; m_rport[i] = '0;
      m_seen[i] = 1'b0; m_vcost[i] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_backpressure();
    test_random(500, 4);
    set_own_id(8'd255);
    test_random(400, 16);
    set_own_id(8'd7);
    test_random(500, 6);
    set_own_id(8'd0);
    test_random(480, 16);

    in_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(negedge clk);
    repeat (2000) @(negedge clk);
    $display("Ran %0d responses: %0d with route changes, %0d lookups found.",
             rsp_count, changed_count, found_count);
    $display("Own id set to 0, 255 and 7; link, vector, lookup and unused ops.");
    if (fail_count == 0 && expected_rsp.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/dvrt_pkg.sv
rtl/dvrt_front.sv
rtl/dvrt_back.sv
rtl/distance_vector_route_table_unit.sv
tb/sv/tb_top.sv
